// ----- src/gpip_pkg.sv -----
// ----------------------------------------------------------------------------
// gpip_pkg: shared types and codes of the geofence point-in-polygon block
// Vertex record, read-pipeline tag, controller states and the absolute
// difference helper that the edge datapath uses.
// ----------------------------------------------------------------------------
package gpip_pkg;

  localparam int COORD_W = 32;
  localparam int COUNT_W = 6;
  localparam int SLOT_W  = 5;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] lat;
    logic signed [COORD_W-1:0] lon;
    logic signed [COORD_W-1:0] alt;
  } vertex_t;

  // Travels alongside each vertex read. The first read of a query fetches the
  // last vertex in use, which only seeds the previous-vertex register.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } edge_tag_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Magnitude of a - b. The difference of two 32-bit values always fits in
  // 32 unsigned bits.
  function automatic logic [COORD_W-1:0] absdiff(input logic signed [COORD_W-1:0] a,
                                                 input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    logic signed [COORD_W:0] nd;
    d  = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    nd = -d;
    return d[COORD_W] ? nd[COORD_W-1:0] : d[COORD_W-1:0];
  endfunction

endpackage

// ----- src/gpip_req_if.sv -----
// ----------------------------------------------------------------------------
// gpip_req_if: input channel of the geofence block
// Valid/ready channel carrying vertex loads and point queries.
// ----------------------------------------------------------------------------
interface gpip_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 mode;
  logic        [gpip_pkg::SLOT_W-1:0]   vertex_index;
  logic signed [gpip_pkg::COORD_W-1:0]  latitude;
  logic signed [gpip_pkg::COORD_W-1:0]  longitude;
  logic signed [gpip_pkg::COORD_W-1:0]  altitude;

  modport source (output valid, mode, vertex_index, latitude, longitude, altitude,
                  input ready);
  modport sink (input valid, mode, vertex_index, latitude, longitude, altitude,
                output ready);
endinterface

// ----- src/gpip_rsp_if.sv -----
// ----------------------------------------------------------------------------
// gpip_rsp_if: result channel of the geofence block
// Valid/ready channel carrying one inside/outside answer per query.
// ----------------------------------------------------------------------------
interface gpip_rsp_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

// ----- src/geofence_point_in_polygon.sv -----
// ----------------------------------------------------------------------------
// geofence_point_in_polygon: point-in-polygon geofence with altitude ceiling
// Vertex loads go into a RAM; a query streams the vertices in use through the
// edge datapath, one per cycle, and answers inside or outside.
// ----------------------------------------------------------------------------
// A query with n vertices in use reads n + 1 RAM words, one per cycle on the
// single read port (none for an empty fence); the answer is registered once
// the output register is free. One item is in work at a time; the next is
// taken once the answer sits in the output register. Reset clears the
// controller and the vertex count; the vertex RAM is not cleared and must be
// loaded before it is queried.
module geofence_point_in_polygon #(
  parameter int MAX_VERTICES = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  gpip_req_if.sink                      req,
  gpip_rsp_if.source                    rsp,
  input  logic                          cfg_wr_en,
  input  logic [gpip_pkg::COUNT_W-1:0]  cfg_wr_data
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int CW = (NW > gpip_pkg::COUNT_W) ? NW : gpip_pkg::COUNT_W;

  gpip_pkg::state_t    state;
  gpip_pkg::state_t    state_next;
  logic [gpip_pkg::COUNT_W-1:0] vertex_count;
  logic [NW-1:0]       n_q;
  logic [NW-1:0]       n_q_next;
  logic [NW-1:0]       rd_cnt;
  logic [NW-1:0]       rd_cnt_next;
  gpip_pkg::vertex_t   point;
  gpip_pkg::edge_tag_t rd_tag;
  gpip_pkg::edge_tag_t issue_tag;
  logic                res_hold;
  logic                res_hold_next;
  logic                out_valid;
  logic                out_res;
  logic                out_load;

  logic                req_fire;
  logic                query_fire;
  logic                ram_we;
  logic [AW-1:0]       ram_raddr;
  gpip_pkg::vertex_t   ram_wdata;
  gpip_pkg::vertex_t   ram_rdata;
  logic [CW-1:0]       count_ext;
  logic [NW-1:0]       n_sat;
  logic                edge_done;
  logic                edge_inside;

  assign req.ready  = (state == gpip_pkg::ST_IDLE);
  assign req_fire   = req.valid && req.ready;
  assign query_fire = req_fire && (req.mode == gpip_pkg::MODE_QUERY);

  // Loads are taken only while idle, so a write never overlaps a query's reads.
  assign ram_we = req_fire && (req.mode == gpip_pkg::MODE_LOAD)
                  && (CW'(req.vertex_index) < CW'(MAX_VERTICES));
  assign ram_wdata.lat = req.latitude;
  assign ram_wdata.lon = req.longitude;
  assign ram_wdata.alt = req.altitude;

  assign count_ext = CW'(vertex_count);
  assign n_sat     = (count_ext > CW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(count_ext);

  assign rsp.valid      = out_valid;
  assign rsp.inside_res = out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_wr_en) begin
      vertex_count <= cfg_wr_data;
    end
  end

  always_comb begin
    state_next    = state;
    n_q_next      = n_q;
    rd_cnt_next   = rd_cnt;
    res_hold_next = res_hold;
    issue_tag     = '0;
    ram_raddr     = '0;
    out_load      = 1'b0;
    case (state)
      gpip_pkg::ST_IDLE: begin
        if (query_fire) begin
          n_q_next    = n_sat;
          rd_cnt_next = '0;
          if (n_sat == '0) begin
            res_hold_next = 1'b1;
            state_next    = gpip_pkg::ST_DONE;
          end else begin
            state_next = gpip_pkg::ST_RUN;
          end
        end
      end
      gpip_pkg::ST_RUN: begin
        // Read order: last vertex in use, then vertices 0 .. n-1.
        ram_raddr       = (rd_cnt == '0) ? AW'(n_q - 1'b1) : AW'(rd_cnt - 1'b1);
        issue_tag.valid = 1'b1;
        issue_tag.first = (rd_cnt == '0);
        issue_tag.last  = (rd_cnt == n_q);
        rd_cnt_next     = rd_cnt + 1'b1;
        if (rd_cnt == n_q) begin
          state_next = gpip_pkg::ST_DRAIN;
        end
      end
      gpip_pkg::ST_DRAIN: begin
        if (edge_done) begin
          res_hold_next = edge_inside;
          state_next    = gpip_pkg::ST_DONE;
        end
      end
      gpip_pkg::ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = gpip_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gpip_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gpip_pkg::ST_IDLE;
      rd_cnt    <= '0;
      n_q       <= '0;
      rd_tag    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_cnt <= rd_cnt_next;
      n_q    <= n_q_next;
      rd_tag <= issue_tag;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_hold <= res_hold_next;
    if (query_fire) begin
      point <= ram_wdata;
    end
    if (out_load) begin
      out_res <= res_hold;
    end
  end

  gpip_ram #(
    .WIDTH ($bits(gpip_pkg::vertex_t)),
    .DEPTH (MAX_VERTICES)
  ) u_vertex_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(req.vertex_index)),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gpip_edge_unit u_edge (
    .clk      (clk),
    .rst      (rst),
    .tag      (rd_tag),
    .vert     (ram_rdata),
    .point    (point),
    .done     (edge_done),
    .in_fence (edge_inside)
  );

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != gpip_pkg::ST_IDLE) |-> !req_fire)
    else $error("item accepted while a query is in work");

  a_write_idle_only: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == gpip_pkg::ST_IDLE))
    else $error("vertex store written during a query");

  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    edge_done |-> (state == gpip_pkg::ST_DRAIN))
    else $error("edge pipeline finished outside the drain phase");

  a_rd_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == gpip_pkg::ST_RUN) |-> (rd_cnt <= n_q) && (n_q != '0))
    else $error("read counter out of range");

  a_load_frees_slot: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && (state == gpip_pkg::ST_IDLE))
    else $error("result load did not take effect");
`endif

endmodule

// ----- src/gpip_ram.sv -----
// ----------------------------------------------------------------------------
// gpip_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module gpip_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/gpip_edge_unit.sv -----
// ----------------------------------------------------------------------------
// gpip_edge_unit: ray-casting edge datapath
// Takes one vertex per cycle from the store, forms the edge from the previous
// vertex, and in three stages tests straddle, crossing side and ceiling.
// ----------------------------------------------------------------------------
module gpip_edge_unit (
  input  logic                clk,
  input  logic                rst,
  input  gpip_pkg::edge_tag_t tag,
  input  gpip_pkg::vertex_t   vert,
  input  gpip_pkg::vertex_t   point,
  output logic                done,
  output logic                in_fence
);

  localparam int W = gpip_pkg::COORD_W;

  gpip_pkg::vertex_t   prev;

  gpip_pkg::edge_tag_t s1_tag;
  logic                s1_straddle;
  logic                s1_lneg;
  logic                s1_rneg;
  logic                s1_alt_fail;
  logic [W-1:0]        s1_amag;
  logic [W-1:0]        s1_bmag;
  logic [W-1:0]        s1_cmag;
  logic [W-1:0]        s1_dmag;

  gpip_pkg::edge_tag_t s2_tag;
  logic                s2_straddle;
  logic                s2_lneg;
  logic                s2_rneg;
  logic                s2_alt_fail;
  logic [2*W-1:0]      s2_lprod;
  logic [2*W-1:0]      s2_rprod;

  logic                flag;
  logic                alt_acc;

  logic                straddle;
  logic                lneg;
  logic                rneg;
  logic                less;
  logic                flag_new;
  logic                alt_new;

  // Stage 1: signs and magnitudes of the four factors. The crossing test is
  // (plon-ilon)*sgn(d)*(jlat-ilat) < (plat-ilat)*|d| with d = jlon-ilon.
  always_comb begin
    straddle = !tag.first && ((vert.lon < point.lon) != (prev.lon < point.lon));
    lneg = ((point.lon < vert.lon) ^ (prev.lon < vert.lon) ^ (prev.lat < vert.lat))
           && (point.lon != vert.lon) && (prev.lat != vert.lat);
    rneg = (point.lat < vert.lat) && (point.lat != vert.lat) && (prev.lon != vert.lon);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag <= '0;
      s2_tag <= '0;
    end else begin
      s1_tag <= tag;
      s2_tag <= s1_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (tag.valid) begin
      prev <= vert;
    end
    s1_straddle <= straddle;
    s1_lneg     <= lneg;
    s1_rneg     <= rneg;
    s1_alt_fail <= vert.alt < point.alt;
    s1_amag     <= gpip_pkg::absdiff(point.lon, vert.lon);
    s1_bmag     <= gpip_pkg::absdiff(prev.lat, vert.lat);
    s1_cmag     <= gpip_pkg::absdiff(point.lat, vert.lat);
    s1_dmag     <= gpip_pkg::absdiff(prev.lon, vert.lon);
    // Stage 2: the two 32 x 32 products.
    s2_straddle <= s1_straddle;
    s2_lneg     <= s1_lneg;
    s2_rneg     <= s1_rneg;
    s2_alt_fail <= s1_alt_fail;
    s2_lprod    <= s1_amag * s1_bmag;
    s2_rprod    <= s1_cmag * s1_dmag;
  end

  // Stage 3: sign-magnitude compare, parity update and ceiling accumulation.
  always_comb begin
    if (s2_lneg != s2_rneg) begin
      less = s2_lneg;
    end else if (s2_lneg) begin
      less = s2_lprod > s2_rprod;
    end else begin
      less = s2_lprod < s2_rprod;
    end
    flag_new = (s2_tag.first ? 1'b0 : flag) ^ (s2_straddle && less);
    alt_new  = (s2_tag.first ? 1'b0 : alt_acc) | s2_alt_fail;
    done     = s2_tag.valid && s2_tag.last;
    in_fence = flag_new && !alt_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag    <= 1'b0;
      alt_acc <= 1'b0;
    end else if (s2_tag.valid) begin
      flag    <= flag_new;
      alt_acc <= alt_new;
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench of the geofence point-in-polygon block
// Loads fence vertices, sets the vertex count between phases and sends point
// queries, with random gaps on the request side and random stalls on the
// answer side. Every answer is checked against a fence model kept here.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W = gpip_pkg::COORD_W;
  localparam int COUNT_W = gpip_pkg::COUNT_W;
  localparam int SLOT_W  = gpip_pkg::SLOT_W;

  localparam int FENCE_SLOTS = 32;
  localparam int SETTLE_CYCLES = FENCE_SLOTS + 12;
  localparam int ITEM_TARGET = 1610;
  localparam logic signed [COORD_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] S32_MIN = 32'sh8000_0000;

  typedef struct {
    logic                      mode;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] lat;
    logic signed [COORD_W-1:0] lon;
    logic signed [COORD_W-1:0] alt;
    int unsigned               gap;
  } fence_item_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [COUNT_W-1:0] cfg_wr_data;

  gpip_req_if req_ch ();
  gpip_rsp_if rsp_ch ();

  geofence_point_in_polygon #(
    .MAX_VERTICES(FENCE_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Fence model, updated as items are accepted.
  logic signed [COORD_W-1:0] fence_lat [FENCE_SLOTS];
  logic signed [COORD_W-1:0] fence_lon [FENCE_SLOTS];
  logic signed [COORD_W-1:0] fence_alt [FENCE_SLOTS];
  logic [COUNT_W-1:0] fence_count = '0;
  bit expected_inside [$];

  // Vertices as planned by the stimulus, ahead of acceptance.
  longint plan_lat [FENCE_SLOTS];
  longint plan_lon [FENCE_SLOTS];
  longint plan_alt [FENCE_SLOTS];

  fence_item_t pending_items [$];
  fence_item_t on_wire;
  int unsigned feed_wait;
  bit feed_armed;
  bit feed_calm;
  bit answer_calm;
  int unsigned answer_stall;
  bit want_inside;

  int items_posted;
  int items_taken;
  int error_count;
  int loads_seen;
  int inside_seen;
  int outside_seen;
  int settings_seen;

  // Shape of the fence in the current phase.
  bit shape_noise;
  int shape_used;
  longint shape_lat;
  longint shape_lon;
  longint shape_reach;
  longint shape_alt;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic signed [COORD_W-1:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return S32_MAX;
    if (v < -64'sd2147483648) return S32_MIN;
    return v[COORD_W-1:0];
  endfunction

  function automatic longint rand_s32();
    return longint'(signed'($urandom));
  endfunction

  function automatic longint rand_span(input longint r);
    return longint'($urandom_range(32'(2 * r), 0)) - r;
  endfunction

  // Ray casting with an altitude ceiling. The crossing test compares
  // cross-products exactly, with both sides scaled by the sign of the edge's
  // longitude span so that the inequality keeps its direction.
  function automatic bit fence_contains(input logic signed [COORD_W-1:0] plat,
                                        input logic signed [COORD_W-1:0] plon,
                                        input logic signed [COORD_W-1:0] palt);
    int n;
    int j;
    bit odd;
    logic signed [71:0] la_i, lo_i, la_j, lo_j, pla, plo, dlon, sgn, lhs, rhs;
    n = (fence_count > FENCE_SLOTS) ? FENCE_SLOTS : int'(fence_count);
    if (n == 0) return 1'b1;
    for (int i = 0; i < n; i++) begin
      if (fence_alt[i] < palt) return 1'b0;
    end
    odd = 1'b0;
    pla = plat;
    plo = plon;
    j = n - 1;
    for (int i = 0; i < n; i++) begin
      la_i = fence_lat[i];
      lo_i = fence_lon[i];
      la_j = fence_lat[j];
      lo_j = fence_lon[j];
      if ((lo_i < plo) != (lo_j < plo)) begin
        dlon = lo_j - lo_i;
        sgn = (dlon < 0) ? -1 : 1;
        lhs = (plo - lo_i) * sgn * (la_j - la_i);
        rhs = (pla - la_i) * dlon * sgn;
        if (lhs < rhs) odd = ~odd;
      end
      j = i;
    end
    return odd;
  endfunction

  function automatic void fence_apply(input fence_item_t it);
    bit in_fence;
    if (it.mode == gpip_pkg::MODE_LOAD) begin
      if (it.slot < FENCE_SLOTS) begin
        fence_lat[it.slot] = it.lat;
        fence_lon[it.slot] = it.lon;
        fence_alt[it.slot] = it.alt;
      end
      loads_seen++;
    end else begin
      in_fence = fence_contains(it.lat, it.lon, it.alt);
      expected_inside.push_back(in_fence);
      if (in_fence) inside_seen++;
      else outside_seen++;
    end
  endfunction

  // Request side: each item waits out its own gap once the channel is free.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      feed_armed = 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        fence_apply(on_wire);
        items_taken++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (!feed_armed && pending_items.size() > 0) begin
          feed_wait = pending_items[0].gap;
          feed_armed = 1'b1;
        end
        if (feed_armed && feed_wait == 0) begin
          on_wire = pending_items.pop_front();
          feed_armed = 1'b0;
          req_ch.valid <= 1'b1;
          req_ch.mode <= on_wire.mode;
          req_ch.vertex_index <= on_wire.slot;
          req_ch.latitude <= on_wire.lat;
          req_ch.longitude <= on_wire.lon;
          req_ch.altitude <= on_wire.alt;
        end else begin
          if (feed_armed) feed_wait--;
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Answer side: a random stall follows each accepted answer, unless the phase is calm.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      answer_stall = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_inside.size() == 0) begin
          $error("inside_res: answer with none expected, expected none, actual %0b",
                 rsp_ch.inside_res);
          error_count++;
        end else begin
          want_inside = expected_inside.pop_front();
          if (rsp_ch.inside_res !== want_inside) begin
            $error("inside_res mismatch: expected %0b, actual %0b",
                   want_inside, rsp_ch.inside_res);
            error_count++;
          end
        end
        answer_stall = answer_calm ? 0 : $urandom_range(11, 0);
      end
      if (answer_stall > 0) begin
        answer_stall--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic post_item(input logic mode, input int slot, input longint lat,
                           input longint lon, input longint alt);
    fence_item_t it;
    it.mode = mode;
    it.slot = SLOT_W'(slot);
    it.lat = clamp32(lat);
    it.lon = clamp32(lon);
    it.alt = clamp32(alt);
    it.gap = feed_calm ? 0 : $urandom_range(11, 0);
    if (mode == gpip_pkg::MODE_LOAD && slot < FENCE_SLOTS) begin
      plan_lat[slot] = it.lat;
      plan_lon[slot] = it.lon;
      plan_alt[slot] = it.alt;
    end
    pending_items.push_back(it);
    items_posted++;
  endtask

  // Waits until every item is taken and answered, then lets a trailing
  // vertex load finish.
  task automatic settle();
    while (items_taken != items_posted || expected_inside.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertex_count(input int n);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= COUNT_W'(n);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    fence_count = COUNT_W'(n);
    settings_seen++;
  endtask

  task automatic load_vertex(input int slot);
    longint lat, lon, alt;
    if (shape_noise) begin
      lat = rand_s32();
      lon = rand_s32();
      alt = rand_s32();
    end else begin
      lat = shape_lat + rand_span(shape_reach);
      lon = shape_lon + rand_span(shape_reach);
      alt = shape_alt + $urandom_range(1 << 20, 0);
      // Repeated longitudes give edges that never straddle.
      if (slot > 0 && $urandom_range(9, 0) == 0) lon = plan_lon[slot - 1];
    end
    post_item(gpip_pkg::MODE_LOAD, slot, lat, lon, alt);
  endtask

  task automatic query_point();
    int kind;
    int a;
    int b;
    longint lat, lon, alt, min_ceiling, box;
    box = shape_reach + shape_reach / 4;
    lat = shape_noise ? rand_s32() : shape_lat + rand_span(box);
    lon = shape_noise ? rand_s32() : shape_lon + rand_span(box);
    alt = rand_s32();
    if (shape_used > 0) begin
      a = $urandom_range(shape_used - 1, 0);
      b = (a + 1) % shape_used;
      kind = $urandom_range(99, 0);
      if (kind >= 45 && kind < 60) begin
        lon = plan_lon[a];
      end else if (kind < 70) begin
        lat = plan_lat[a];
        lon = plan_lon[a];
      end else if (kind < 80) begin
        // Midpoint of an edge: often exactly on the boundary.
        lat = (plan_lat[a] + plan_lat[b]) >>> 1;
        lon = (plan_lon[a] + plan_lon[b]) >>> 1;
      end else if (kind < 90) begin
        lat = plan_lat[a];
      end else if (kind < 95) begin
        lat = rand_s32();
        lon = rand_s32();
      end
      min_ceiling = plan_alt[0];
      for (int i = 1; i < shape_used; i++) begin
        if (plan_alt[i] < min_ceiling) min_ceiling = plan_alt[i];
      end
      kind = $urandom_range(99, 0);
      if (kind < 65) alt = min_ceiling - $urandom_range(1 << 20, 0);
      else if (kind < 80) alt = min_ceiling;
      else if (kind < 90) alt = min_ceiling + 1;
    end
    post_item(gpip_pkg::MODE_QUERY, $urandom_range(FENCE_SLOTS - 1, 0), lat, lon, alt);
  endtask

  task automatic run_fence_phase();
    int pick;
    int n;
    int extra;
    int queries;
    pick = $urandom_range(99, 0);
    if (pick < 8) n = 0;
    else if (pick < 12) n = 1;
    else if (pick < 16) n = 2;
    else if (pick < 20) n = $urandom_range(63, FENCE_SLOTS + 1);
    else if (pick < 32) n = FENCE_SLOTS;
    else n = $urandom_range(12, 3);
    shape_used = (n > FENCE_SLOTS) ? FENCE_SLOTS : n;
    shape_noise = ($urandom_range(6, 0) == 0);
    shape_lat = rand_s32() >>> 2;
    shape_lon = rand_s32() >>> 2;
    shape_reach = longint'(1) << $urandom_range(29, 3);
    shape_alt = rand_s32() >>> 2;
    settle();
    feed_calm = ($urandom_range(3, 0) == 0);
    answer_calm = ($urandom_range(3, 0) == 0);
    set_vertex_count(n);
    for (int k = 0; k < shape_used; k++) load_vertex(k);
    if (shape_used < FENCE_SLOTS) begin
      extra = $urandom_range(2, 0);
      repeat (extra) load_vertex($urandom_range(FENCE_SLOTS - 1, shape_used));
    end
    queries = $urandom_range(36, 8);
    repeat (queries) begin
      // Now and then a vertex in use moves between queries.
      if (shape_used > 0 && $urandom_range(9, 0) == 0) begin
        load_vertex($urandom_range(shape_used - 1, 0));
      end
      query_point();
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    req_ch.valid = 1'b0;
    req_ch.mode = gpip_pkg::MODE_LOAD;
    req_ch.vertex_index = '0;
    req_ch.latitude = '0;
    req_ch.longitude = '0;
    req_ch.altitude = '0;
    rsp_ch.ready = 1'b0;
    feed_calm = 1'b0;
    answer_calm = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Empty fence straight out of reset: every point is inside.
    post_item(gpip_pkg::MODE_QUERY, FENCE_SLOTS - 1, S32_MAX, S32_MIN, S32_MAX);
    post_item(gpip_pkg::MODE_QUERY, 0, S32_MIN, S32_MAX, S32_MIN);
    post_item(gpip_pkg::MODE_QUERY, 5, 0, 0, 0);

    // A square fence with one higher ceiling.
    post_item(gpip_pkg::MODE_LOAD, 0, -1000, -1000, 5000);
    post_item(gpip_pkg::MODE_LOAD, 1, -1000, 1000, 5000);
    post_item(gpip_pkg::MODE_LOAD, 2, 1000, 1000, 6000);
    post_item(gpip_pkg::MODE_LOAD, 3, 1000, -1000, 5000);
    post_item(gpip_pkg::MODE_LOAD, FENCE_SLOTS - 1, S32_MAX, S32_MIN, S32_MAX);
    settle();
    set_vertex_count(4);
    post_item(gpip_pkg::MODE_QUERY, 0, 0, 0, 0);
    post_item(gpip_pkg::MODE_QUERY, 0, 0, 0, 5000);
    post_item(gpip_pkg::MODE_QUERY, 0, 0, 0, 5001);
    post_item(gpip_pkg::MODE_QUERY, 0, 0, 2000, 0);
    post_item(gpip_pkg::MODE_QUERY, 0, 2000, 0, 0);
    post_item(gpip_pkg::MODE_QUERY, 0, -2000, 0, 0);
    post_item(gpip_pkg::MODE_QUERY, 0, 1000, 0, 0);
    post_item(gpip_pkg::MODE_QUERY, 0, -1000, 0, 0);
    post_item(gpip_pkg::MODE_QUERY, 0, 0, -1000, 0);
    post_item(gpip_pkg::MODE_QUERY, 0, -1000, -1000, 0);
    post_item(gpip_pkg::MODE_QUERY, FENCE_SLOTS - 1, S32_MAX, S32_MIN, S32_MIN);
    post_item(gpip_pkg::MODE_QUERY, 0, S32_MIN, S32_MAX, S32_MIN);
    settle();
    set_vertex_count(0);
    post_item(gpip_pkg::MODE_QUERY, 0, 7, 7, S32_MAX);

    while (items_posted < ITEM_TARGET) run_fence_phase();

    settle();
    $display("Covered %0d vertex loads and %0d queries (%0d inside, %0d outside)",
             loads_seen, inside_seen + outside_seen, inside_seen, outside_seen);
    $display("over %0d vertex count settings, including empty and oversized fences.",
             settings_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/gpip_pkg.sv
src/gpip_req_if.sv
src/gpip_rsp_if.sv
src/gpip_ram.sv
src/gpip_edge_unit.sv
src/geofence_point_in_polygon.sv
dv/tb_top.sv
